FILE: src/dlw_pkg.sv
// ----------------------------------------------------------------------------
// dlw_pkg
// shared widths, defaults, controller states and the command/status bundles
// of the dda line pixel walker
// ----------------------------------------------------------------------------
package dlw_pkg;

   localparam int COORD_W       = 14;
   localparam int CELL_W        = 6;
   localparam int MAX_CELLS     = 64;
   localparam int CNT_W         = $clog2(MAX_CELLS);
   localparam int FRAC_BITS_DEF = 8;
   localparam int GRID_SIZE_DEF = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_SLOPE,
      ST_WALK
   } dlw_state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic slope_load;
      logic walk_step;
   } dlw_cmd_type;

   typedef struct packed {
      logic end_valid;
      logic zero_len;
      logic vertical;
      logic div_done;
      logic walk_cond;
      logic walk_last;
   } dlw_status_type;

endpackage

FILE: src/dlw_div.sv
// ----------------------------------------------------------------------------
// dlw_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dlw_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             div_done
);
   localparam int DC_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DC_W-1:0]  cnt_ff,  cnt_in;
   logic             run_ff,  run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic             ge;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[NUM_W-1]};
      ge        = rem_shift >= {1'b0, den};
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = done_ff;
      if (div_start) begin
         rem_in  = '0;
         quot_in = num;
         cnt_in  = DC_W'(NUM_W);
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         rem_in  = ge ? DEN_W'(rem_shift - {1'b0, den}) : DEN_W'(rem_shift);
         quot_in = {quot_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DC_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quot     = quot_ff;
   assign div_done = done_ff;

endmodule

FILE: src/dlw_ctrl.sv
// ----------------------------------------------------------------------------
// dlw_ctrl
// line walk sequencer: setup, slope divide (skipped for vertical lines), then one cell per cycle
// ----------------------------------------------------------------------------
module dlw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dlw_pkg::dlw_status_type status,
   output dlw_pkg::dlw_cmd_type    cmd
);
   import dlw_pkg::*;

   dlw_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (!status.end_valid || status.zero_len) state_in = ST_IDLE;
            else if (status.vertical)                 state_in = ST_WALK;
            else                                      state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_SLOPE;
         end
         ST_SLOPE: state_in = ST_WALK;
         ST_WALK: begin
            if (!status.walk_cond || status.walk_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_SETUP: begin
            if (status.end_valid && !status.zero_len) begin
               cmd.slope_load = status.vertical;
               cmd.div_start  = !status.vertical;
            end
         end
         ST_DIV:   cmd = '0;
         ST_SLOPE: cmd.slope_load = 1'b1;
         ST_WALK:  cmd.walk_step = status.walk_cond;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/dlw_datapath.sv
// ----------------------------------------------------------------------------
// dlw_datapath
// line registers, y accumulator, walk tests and the registered result beat
// ----------------------------------------------------------------------------
module dlw_datapath #(
   parameter int FRAC_BITS = 8,
   parameter int GRID_SIZE = 64,
   parameter int NUM_W     = 22,
   parameter int DEN_W     = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dlw_pkg::dlw_cmd_type          cmd,
   output dlw_pkg::dlw_status_type       status,
   input  logic [dlw_pkg::COORD_W-1:0]   req_start_x,
   input  logic [dlw_pkg::COORD_W-1:0]   req_start_y,
   input  logic [dlw_pkg::COORD_W-1:0]   req_end_x,
   input  logic [dlw_pkg::COORD_W-1:0]   req_end_y,
   input  logic                          req_end_valid,
   output logic [NUM_W-1:0]              div_num,
   output logic [DEN_W-1:0]              div_den,
   input  logic [NUM_W-1:0]              div_quot,
   input  logic                          div_done,
   output logic                          rsp_strobe,
   output logic [dlw_pkg::CELL_W-1:0]    rsp_cell_x,
   output logic [dlw_pkg::CELL_W-1:0]    rsp_cell_y,
   output logic                          rsp_last_cell
);
   import dlw_pkg::*;

   localparam int INT_W = (COORD_W > FRAC_BITS) ? COORD_W - FRAC_BITS : 1;
   localparam int Y_W   = FRAC_BITS + COORD_W;
   localparam int YI_W  = Y_W - FRAC_BITS;
   localparam int CMP_W = INT_W + 8;
   localparam logic [NUM_W-1:0] LIM = NUM_W'(GRID_SIZE * (1 << FRAC_BITS));
   localparam logic signed [Y_W-1:0] ONE = Y_W'(1 << FRAC_BITS);

   logic [INT_W-1:0]        x_ff, x_in, xend_ff, xend_in;
   logic signed [Y_W-1:0]   y_ff, y_in, rowlim_ff, rowlim_in, ystep_ff, ystep_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    valid_ff, vert_ff, zero_ff, xpos_ff, yneg_ff;
   logic                    valid_in, vert_in, zero_in, xpos_in, yneg_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic                    strobe_ff, strobe_in, last_ff, last_in;
   logic [CELL_W-1:0]       cx_ff, cx_in, cy_ff, cy_in;

   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W-1:0]      adx, ady, ey_floor;
   logic [NUM_W-1:0]        mag;
   logic [INT_W-1:0]        x_next;
   logic signed [Y_W-1:0]   y_next;
   logic                    cond_now, cond_next;
   logic [YI_W-1:0]         y_int;

   function automatic logic walk_test(input logic [INT_W-1:0] xv,
                                      input logic signed [Y_W-1:0] yv,
                                      input logic vert, input logic xpos,
                                      input logic yneg,
                                      input logic [INT_W-1:0] xe,
                                      input logic signed [Y_W-1:0] rl);
      logic r;
      if (vert) r = yneg ? (yv >= rl) : (yv <= rl);
      else      r = xpos ? (xv < xe) : (xv > xe);
      return r;
   endfunction

   always_comb begin
      dx       = $signed({1'b0, req_end_x}) - $signed({1'b0, req_start_x});
      dy       = $signed({1'b0, req_end_y}) - $signed({1'b0, req_start_y});
      adx      = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
      ady      = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
      ey_floor = (req_end_y >> FRAC_BITS) << FRAC_BITS;
      mag      = (div_quot > LIM) ? LIM : div_quot;

      x_next    = vert_ff ? x_ff : (xpos_ff ? x_ff + 1'b1 : x_ff - 1'b1);
      y_next    = y_ff + ystep_ff;
      cond_now  = walk_test(x_ff, y_ff, vert_ff, xpos_ff, yneg_ff, xend_ff, rowlim_ff);
      cond_next = walk_test(x_next, y_next, vert_ff, xpos_ff, yneg_ff, xend_ff,
                            rowlim_ff);

      x_in      = x_ff;
      y_in      = y_ff;
      xend_in   = xend_ff;
      rowlim_in = rowlim_ff;
      ystep_in  = ystep_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff;
      vert_in   = vert_ff;
      zero_in   = zero_ff;
      xpos_in   = xpos_ff;
      yneg_in   = yneg_ff;
      num_in    = num_ff;
      den_in    = den_ff;

      if (cmd.load) begin
         x_in      = INT_W'(req_start_x >> FRAC_BITS);
         xend_in   = INT_W'(req_end_x >> FRAC_BITS);
         y_in      = $signed({{(Y_W - COORD_W){1'b0}}, req_start_y});
         rowlim_in = $signed({{(Y_W - COORD_W){1'b0}}, ey_floor});
         cnt_in    = '0;
         valid_in  = req_end_valid;
         vert_in   = (dx == '0);
         zero_in   = (dx == '0) && (dy == '0);
         xpos_in   = !dx[COORD_W] && (dx != '0);
         yneg_in   = dy[COORD_W];
         num_in    = NUM_W'(ady) << FRAC_BITS;
         den_in    = DEN_W'(adx);
      end
      if (cmd.slope_load) begin
         if (vert_ff) ystep_in = yneg_ff ? -ONE : ONE;
         else         ystep_in = yneg_ff ? -Y_W'(mag) : Y_W'(mag);
      end
      if (cmd.walk_step) begin
         x_in   = x_next;
         y_in   = y_next;
         cnt_in = cnt_ff + 1'b1;
      end

      y_int = y_ff[Y_W-1:FRAC_BITS];
      if (CMP_W'(x_ff) >= CMP_W'(GRID_SIZE)) cx_in = CELL_W'(GRID_SIZE - 1);
      else                                   cx_in = CELL_W'(x_ff);
      if (y_ff[Y_W-1])                       cy_in = '0;
      else if (y_int >= YI_W'(GRID_SIZE))    cy_in = CELL_W'(GRID_SIZE - 1);
      else                                   cy_in = CELL_W'(y_int);
      strobe_in = cmd.walk_step;
      last_in   = (cnt_ff == CNT_W'(MAX_CELLS - 1)) || !cond_next;
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      xend_ff   <= xend_in;
      rowlim_ff <= rowlim_in;
      ystep_ff  <= ystep_in;
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      xpos_ff   <= xpos_in;
      yneg_ff   <= yneg_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      last_ff   <= last_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         vert_ff   <= 1'b0;
         zero_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         vert_ff   <= vert_in;
         zero_ff   <= zero_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      status.end_valid = valid_ff;
      status.zero_len  = zero_ff;
      status.vertical  = vert_ff;
      status.div_done  = div_done;
      status.walk_cond = cond_now;
      status.walk_last = last_in;
   end

   assign div_num       = num_ff;
   assign div_den       = den_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_cell_x    = cx_ff;
   assign rsp_cell_y    = cy_ff;
   assign rsp_last_cell = last_ff;

endmodule

FILE: src/dda_line_pixel_walker.sv
// first cell: a vertical line goes from setup straight to the walk, else the walk waits on
// the bit-serial slope divider (one quotient bit per cycle) and the slope load
// throughput: one cell per cycle once walking, up to 64 cells, then back to idle
// busy is high from setup until the walk ends; the last cell beat follows in idle
// reset: synchronous, clears the sequencer and the result strobe; results cannot stall
// ----------------------------------------------------------------------------
// dda_line_pixel_walker
// walks the grid cells of an x-stepping dda line (y-stepping when vertical) between two fixed-point points
// ----------------------------------------------------------------------------
module dda_line_pixel_walker #(
   parameter int FRAC_BITS = dlw_pkg::FRAC_BITS_DEF,
   parameter int GRID_SIZE = dlw_pkg::GRID_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dlw_pkg::COORD_W-1:0] req_start_x,
   input  logic [dlw_pkg::COORD_W-1:0] req_start_y,
   input  logic [dlw_pkg::COORD_W-1:0] req_end_x,
   input  logic [dlw_pkg::COORD_W-1:0] req_end_y,
   input  logic                        req_end_valid,
   output logic                        rsp_strobe,
   output logic [dlw_pkg::CELL_W-1:0]  rsp_cell_x,
   output logic [dlw_pkg::CELL_W-1:0]  rsp_cell_y,
   output logic                        rsp_last_cell
);
   import dlw_pkg::*;

   localparam int NUM_W = COORD_W + FRAC_BITS;
   localparam int DEN_W = COORD_W;

   dlw_cmd_type      cmd;
   dlw_status_type   status;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;
   logic             div_done;

   dlw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dlw_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (cmd.div_start),
      .num       (div_num),
      .den       (div_den),
      .quot      (div_quot),
      .div_done  (div_done)
   );

   dlw_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .GRID_SIZE (GRID_SIZE),
      .NUM_W     (NUM_W),
      .DEN_W     (DEN_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_end_valid (req_end_valid),
      .div_num       (div_num),
      .div_den       (div_den),
      .div_quot      (div_quot),
      .div_done      (div_done),
      .rsp_strobe    (rsp_strobe),
      .rsp_cell_x    (rsp_cell_x),
      .rsp_cell_y    (rsp_cell_y),
      .rsp_last_cell (rsp_last_cell)
   );

endmodule

FILE: tb/dda_line_pixel_walker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_pixel_walker_tb
// self-checking bench for the dda line pixel walker: a table of directed lines
// (degenerate, vertical, one-cell, full-grid and saturated-slope cases) then
// random lines sent in bursts, every cell beat scored against the table or a line predictor
// ----------------------------------------------------------------------------
module dda_line_pixel_walker_tb;

   localparam int FRAC      = dlw_pkg::FRAC_BITS_DEF;
   localparam int GRID      = dlw_pkg::GRID_SIZE_DEF;
   localparam int CELL_CAP  = dlw_pkg::MAX_CELLS;
   localparam int RAND_LINES = 390;
   localparam int N_DIR     = 21;

   typedef struct packed {
      logic [dlw_pkg::CELL_W-1:0] x;
      logic [dlw_pkg::CELL_W-1:0] y;
      logic                       last;
   } cell_type;

   typedef struct packed {
      logic [dlw_pkg::COORD_W-1:0] sx;
      logic [dlw_pkg::COORD_W-1:0] sy;
      logic [dlw_pkg::COORD_W-1:0] ex;
      logic [dlw_pkg::COORD_W-1:0] ey;
      logic                        ev;
      logic                        typed;
      logic                        one_cell;
      logic [dlw_pkg::CELL_W-1:0]  cx;
      logic [dlw_pkg::CELL_W-1:0]  cy;
   } line_row_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [dlw_pkg::COORD_W-1:0] req_start_x;
   logic [dlw_pkg::COORD_W-1:0] req_start_y;
   logic [dlw_pkg::COORD_W-1:0] req_end_x;
   logic [dlw_pkg::COORD_W-1:0] req_end_y;
   logic                        req_end_valid;
   logic                        rsp_strobe;
   logic [dlw_pkg::CELL_W-1:0]  rsp_cell_x;
   logic [dlw_pkg::CELL_W-1:0]  rsp_cell_y;
   logic                        rsp_last_cell;

   cell_type pending_cells[$];
   int       mismatch_count = 0;

   // sx, sy, ex, ey, valid, typed, one cell, cell x, cell y
   line_row_type dir_rows [N_DIR] = '{
      '{14'h0100, 14'h0100, 14'h3F00, 14'h3F00, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h3FFF, 14'h3FFF, 14'h0000, 14'h0000, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h0000, 14'h0000, 14'h0000, 14'h0000, 1'b1, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b1, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h0500, 14'h0700, 14'h0500, 14'h0780, 1'b1, 1'b1, 1'b1, 6'd5,  6'd7},
      '{14'h0500, 14'h0740, 14'h0500, 14'h07C0, 1'b1, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h0500, 14'h0780, 14'h0500, 14'h0700, 1'b1, 1'b1, 1'b1, 6'd5,  6'd7},
      '{14'h0510, 14'h0200, 14'h05F0, 14'h3000, 1'b1, 1'b1, 1'b0, 6'd0,  6'd0},
      '{14'h0300, 14'h0400, 14'h0400, 14'h0400, 1'b1, 1'b1, 1'b1, 6'd3,  6'd4},
      '{14'h0400, 14'h0400, 14'h0300, 14'h0400, 1'b1, 1'b1, 1'b1, 6'd4,  6'd4},
      '{14'h00FF, 14'h0000, 14'h01FE, 14'h3FFF, 1'b1, 1'b1, 1'b1, 6'd0,  6'd0},
      '{14'h01FE, 14'h3FFF, 14'h00FF, 14'h0000, 1'b1, 1'b1, 1'b1, 6'd1,  6'd63},
      '{14'h0000, 14'h0000, 14'h0000, 14'h3FFF, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h0000, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h0000, 14'h0000, 14'h3FFF, 14'h3FFF, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h3FFF, 14'h3FFF, 14'h0000, 14'h0000, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h0000, 14'h3FFF, 14'h3FFF, 14'h0000, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h3FFF, 14'h0000, 14'h0000, 14'h3FFF, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h1280, 14'h2A40, 14'h2D10, 14'h0B7F, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h2C33, 14'h05C1, 14'h0A0E, 14'h2F9A, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0},
      '{14'h0F00, 14'h1F80, 14'h0F40, 14'h0055, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0}
   };

   dda_line_pixel_walker u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_end_valid (req_end_valid),
      .rsp_strobe    (rsp_strobe),
      .rsp_cell_x    (rsp_cell_x),
      .rsp_cell_y    (rsp_cell_y),
      .rsp_last_cell (rsp_last_cell)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic cell_type grid_cell(input longint col, input longint yfix);
      cell_type c;
      longint   row;
      if (col < 0) col = 0;
      if (col >= GRID) col = GRID - 1;
      if (yfix < 0) begin
         row = 0;
      end else begin
         row = yfix >>> FRAC;
         if (row >= GRID) row = GRID - 1;
      end
      c.x    = col[dlw_pkg::CELL_W-1:0];
      c.y    = row[dlw_pkg::CELL_W-1:0];
      c.last = 1'b0;
      return c;
   endfunction

   task automatic predict_line(input line_row_type r);
      longint   one, dx, dy, x, xend, rowlim, y, slope, lim;
      cell_type walk[$];
      cell_type c;
      one    = longint'(1) << FRAC;
      dx     = longint'(r.ex) - longint'(r.sx);
      dy     = longint'(r.ey) - longint'(r.sy);
      x      = longint'(r.sx) >>> FRAC;
      xend   = longint'(r.ex) >>> FRAC;
      rowlim = (longint'(r.ey) >>> FRAC) * one;
      y      = longint'(r.sy);
      if (r.ev) begin
         if (dx == 0) begin
            if (dy < 0) begin
               while (y >= rowlim && walk.size() < CELL_CAP) begin
                  walk.push_back(grid_cell(x, y));
                  y -= one;
               end
            end else if (dy > 0) begin
               while (y <= rowlim && walk.size() < CELL_CAP) begin
                  walk.push_back(grid_cell(x, y));
                  y += one;
               end
            end
         end else begin
            lim   = longint'(GRID) * one;
            slope = (dy * one) / dx;
            if (slope > lim) slope = lim;
            if (slope < -lim) slope = -lim;
            if (dx > 0) begin
               while (x < xend && walk.size() < CELL_CAP) begin
                  walk.push_back(grid_cell(x, y));
                  x += 1;
                  y += slope;
               end
            end else begin
               while (x > xend && walk.size() < CELL_CAP) begin
                  walk.push_back(grid_cell(x, y));
                  x -= 1;
                  y -= slope;
               end
            end
         end
      end
      if (walk.size() > 0) begin
         c = walk[walk.size()-1];
         c.last = 1'b1;
         walk[walk.size()-1] = c;
      end
      foreach (walk[i]) pending_cells.push_back(walk[i]);
   endtask

   function automatic line_row_type rand_line();
      line_row_type r;
      r    = '0;
      r.sx = dlw_pkg::COORD_W'($urandom);
      r.sy = dlw_pkg::COORD_W'($urandom);
      r.ex = dlw_pkg::COORD_W'($urandom);
      r.ey = dlw_pkg::COORD_W'($urandom);
      r.ev = 1'b1;
      case ($urandom_range(0, 11))
         0: begin
            r.ev = 1'b0;
         end
         1, 2: begin
            r.ex = r.sx;
         end
         3: begin
            r.ex = {r.sx[13:8], 8'($urandom)};
         end
         4: begin
            r.ey = r.sy;
         end
         5: begin
            r.ex = r.sx;
            r.ey = r.sy;
         end
         6, 7: begin
            r.ex = r.sx + 14'($urandom_range(0, 1023)) - 14'd512;
         end
         default: ;
      endcase
      return r;
   endfunction

   // drive one line and hold it until the block takes the beat
   task automatic send_line(input line_row_type r);
      cell_type c;
      req_start_x   <= r.sx;
      req_start_y   <= r.sy;
      req_end_x     <= r.ex;
      req_end_y     <= r.ey;
      req_end_valid <= r.ev;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      if (r.typed) begin
         if (r.one_cell) begin
            c.x    = r.cx;
            c.y    = r.cy;
            c.last = 1'b1;
            pending_cells.push_back(c);
         end
      end else begin
         predict_line(r);
      end
   endtask

   task automatic drain_cells();
      start <= 1'b0;
      do @(posedge clock); while (pending_cells.size() != 0);
   endtask

   always @(posedge clock) begin
      cell_type want;
      if (!reset && rsp_strobe) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected cell beat x=%0d y=%0d last=%0b",
                   rsp_cell_x, rsp_cell_y, rsp_last_cell);
            mismatch_count++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_cell_x !== want.x) begin
               $error("cell_x expected %0d actual %0d", want.x, rsp_cell_x);
               mismatch_count++;
            end
            if (rsp_cell_y !== want.y) begin
               $error("cell_y expected %0d actual %0d", want.y, rsp_cell_y);
               mismatch_count++;
            end
            if (rsp_last_cell !== want.last) begin
               $error("last_cell expected %0b actual %0b", want.last, rsp_last_cell);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int burst;
      int done_lines;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_start_x   <= '0;
      req_start_y   <= '0;
      req_end_x     <= '0;
      req_end_y     <= '0;
      req_end_valid <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_line(dir_rows[i]);
      drain_cells();

      done_lines = 0;
      burst      = 0;
      while (done_lines < RAND_LINES) begin
         if (burst == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
         end
         send_line(rand_line());
         burst--;
         done_lines++;
         if (done_lines == RAND_LINES / 2) drain_cells();
      end

      drain_cells();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
